### sv/kiwi_drive_inverse_kinematics_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the kiwi drive inverse kinematics unit
// Clocked concurrent assertions with an active-low reset that disables them.
// ----------------------------------------------------------------------------
`ifndef KIWI_DRIVE_INVERSE_KINEMATICS_UNIT_ASSERT_SVH
`define KIWI_DRIVE_INVERSE_KINEMATICS_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define KDIK_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define KDIK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/kdik_pkg.sv
// ----------------------------------------------------------------------------
// kdik_pkg
// Types, widths, register codes and reset values of the kiwi drive unit.
// ----------------------------------------------------------------------------
package kdik_pkg;

	localparam int NWHEEL     = 3;
	localparam int VEL_W      = 16;
	localparam int COEF_W     = 16;
	localparam int OFS_W      = 12;
	localparam int LIM_W      = 20;
	localparam int SPD_W      = 21;
	localparam int MAG_W      = 20;
	localparam int PROD_W     = VEL_W + COEF_W;
	localparam int ROT_W      = VEL_W + OFS_W + 1;
	localparam int ROT_SHIFT  = 6;
	localparam int ACC_W      = 36;
	localparam int FRAC_BITS  = 14;
	localparam int QUO_W      = ACC_W - FRAC_BITS;
	localparam int NUM_W      = MAG_W + LIM_W;
	localparam int DIV_STEPS  = MAG_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = LIM_W;

	// stage 1..3 front, 4 magnitude, 5 largest, 6 products, 7..26 divide, 27 select
	localparam int FRONT_STAGES = 3;
	localparam int DIV_FIRST    = FRONT_STAGES + 4;
	localparam int LAST_STAGE   = DIV_FIRST + DIV_STEPS;

	typedef logic signed [VEL_W-1:0]  vel_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [ROT_W-1:0]  rot_t;
	typedef logic signed [SPD_W-1:0]  speed_t;
	typedef logic        [MAG_W-1:0]  mag_t;
	typedef logic        [NUM_W-1:0]  num_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_COS  = 3'd0,
		CFG_A_SIN  = 3'd1,
		CFG_B_COS  = 3'd2,
		CFG_B_SIN  = 3'd3,
		CFG_C_COS  = 3'd4,
		CFG_C_SIN  = 3'd5,
		CFG_OFFSET = 3'd6,
		CFG_LIMIT  = 3'd7
	} cfg_idx_t;

	localparam logic signed [QUO_W-1:0] SAT_HI = 22'sd1048575;
	localparam logic signed [QUO_W-1:0] SAT_LO = -22'sd1048575;

	localparam coef_t A_COS_RST = 16'sd16384;
	localparam coef_t A_SIN_RST = 16'sd0;
	localparam coef_t B_COS_RST = -16'sd8192;
	localparam coef_t B_SIN_RST = 16'sd14189;
	localparam coef_t C_COS_RST = -16'sd8192;
	localparam coef_t C_SIN_RST = -16'sd14189;
	localparam logic [OFS_W-1:0] OFFSET_RST = 12'd200;
	localparam logic [LIM_W-1:0] LIMIT_RST  = 20'd4000;

endpackage

### sv/kdik_if.sv
// ----------------------------------------------------------------------------
// kdik_cmd_if / kdik_wheel_if
// Valid/ready channels for velocity commands and wheel speed results.
// ----------------------------------------------------------------------------
interface kdik_cmd_if;
	import kdik_pkg::*;
	logic valid;
	logic ready;
	vel_t vel_x;
	vel_t vel_y;
	vel_t turn_rate;
	modport source(output valid, vel_x, vel_y, turn_rate, input ready);
	modport sink(input valid, vel_x, vel_y, turn_rate, output ready);
endinterface

interface kdik_wheel_if;
	import kdik_pkg::*;
	logic   valid;
	logic   ready;
	speed_t wheel_a_speed;
	speed_t wheel_b_speed;
	speed_t wheel_c_speed;
	logic   was_scaled;
	modport source(output valid, wheel_a_speed, wheel_b_speed, wheel_c_speed, was_scaled,
		input ready);
	modport sink(input valid, wheel_a_speed, wheel_b_speed, wheel_c_speed, was_scaled,
		output ready);
endinterface

### sv/kdik_wheel_front.sv
// ----------------------------------------------------------------------------
// kdik_wheel_front
// Per-wheel projection: multiply, sum in Q.14, truncate and saturate.
// ----------------------------------------------------------------------------
module kdik_wheel_front (
	input  logic            clk,
	input  logic            en,
	input  kdik_pkg::vel_t  vel_x,
	input  kdik_pkg::vel_t  vel_y,
	input  kdik_pkg::coef_t coef_cos,
	input  kdik_pkg::coef_t coef_sin,
	input  kdik_pkg::rot_t  rot_s1,
	output kdik_pkg::speed_t speed_s3
);
	import kdik_pkg::*;

	logic signed [PROD_W-1:0]         pc_s1;
	logic signed [PROD_W-1:0]         ps_s1;
	logic signed [ROT_W+ROT_SHIFT-1:0] rot_sh;
	logic signed [ACC_W-1:0]          acc_s2;
	logic signed [ACC_W-1:0]          acc_bias;
	logic signed [QUO_W-1:0]          quo;
	speed_t                           speed_d;

	// rotation term is Q.8; move it to Q.14
	assign rot_sh = {rot_s1, {ROT_SHIFT{1'b0}}};

	// bias negatives so the shift truncates toward zero
	assign acc_bias = acc_s2 + ACC_W'({FRAC_BITS{acc_s2[ACC_W-1]}});
	assign quo      = acc_bias[ACC_W-1:FRAC_BITS];

	always_comb begin
		if (quo > SAT_HI) begin
			speed_d = SAT_HI[SPD_W-1:0];
		end else if (quo < SAT_LO) begin
			speed_d = SAT_LO[SPD_W-1:0];
		end else begin
			speed_d = quo[SPD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pc_s1    <= vel_x * coef_cos;
			ps_s1    <= vel_y * coef_sin;
			acc_s2   <= ACC_W'(pc_s1) + ACC_W'(ps_s1) + ACC_W'(rot_sh);
			speed_s3 <= speed_d;
		end
	end

endmodule

### sv/kdik_div_lane.sv
// ----------------------------------------------------------------------------
// kdik_div_lane
// Pipelined restoring divider, one quotient bit per stage, plus sign restore or pass-through of the unscaled speed.
// ----------------------------------------------------------------------------
module kdik_div_lane (
	input  logic             clk,
	input  logic             en,
	input  kdik_pkg::num_t   num,
	input  kdik_pkg::mag_t   den,
	input  kdik_pkg::speed_t spd,
	input  logic             scaled,
	output kdik_pkg::speed_t speed_out
);
	import kdik_pkg::*;

	mag_t   rem_q [DIV_STEPS];
	mag_t   nq_q  [DIV_STEPS];
	mag_t   den_q [DIV_STEPS];
	speed_t spd_q [DIV_STEPS];

	logic [SPD_W-1:0] quo_ext;

	// The high half of the numerator is already below the divisor, so the
	// quotient fits in the low half: shift numerator bits out, quotient bits in.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		mag_t       r_in;
		mag_t       nq_in;
		mag_t       d_in;
		speed_t     s_in;
		logic [MAG_W:0] trial;
		logic       ge;

		if (k == 0) begin : g_first
			assign r_in  = num[NUM_W-1:MAG_W];
			assign nq_in = num[MAG_W-1:0];
			assign d_in  = den;
			assign s_in  = spd;
		end else begin : g_next
			assign r_in  = rem_q[k-1];
			assign nq_in = nq_q[k-1];
			assign d_in  = den_q[k-1];
			assign s_in  = spd_q[k-1];
		end

		assign trial = {r_in, nq_in[MAG_W-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? MAG_W'(trial - {1'b0, d_in}) : trial[MAG_W-1:0];
				nq_q[k]  <= {nq_in[MAG_W-2:0], ge};
				den_q[k] <= d_in;
				spd_q[k] <= s_in;
			end
		end
	end

	assign quo_ext = {1'b0, nq_q[DIV_STEPS-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (!scaled) begin
				speed_out <= spd_q[DIV_STEPS-1];
			end else if (spd_q[DIV_STEPS-1][SPD_W-1]) begin
				speed_out <= -quo_ext;
			end else begin
				speed_out <= quo_ext;
			end
		end
	end

endmodule

### sv/kiwi_drive_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// kiwi_drive_inverse_kinematics_unit
// Three-wheel omni drive inverse kinematics with speed limit normalization.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  cmd     | in        | valid / ready       | vel_x, vel_y, turn_rate
//  wheel   | out       | valid / ready       | wheel_a/b/c_speed, was_scaled
//  cfg     | in        | cfg_wr_en (no wait) | cfg_wr_index, cfg_wr_data
//
//  One request enters per cycle while the skid register is empty.
//  The divider has 20 stages, one quotient bit per stage.
//  Reset clears the valid bits, including the skid valid bit, and loads the register defaults.
//  A stalled result is parked in a skid register; the pipeline freezes as a whole
//  only while that register is full, so no request is lost or repeated.
//
// Stage map:
//   1   products vel_x*cos, vel_y*sin, turn_rate*offset
//   2   sum in Q.14
//   3   truncate toward zero, saturate to +-1048575
//   4   magnitudes
//   5   largest magnitude
//   6   magnitude * limit, scale decision
//   7..26  restoring division by the largest magnitude
//   27  restore sign, or pass the unscaled speed
// ----------------------------------------------------------------------------
module kiwi_drive_inverse_kinematics_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	kdik_cmd_if.sink                             cmd,
	kdik_wheel_if.source                         wheel,
	input  logic                                 cfg_wr_en,
	input  logic [kdik_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
	input  logic [kdik_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);
	import kdik_pkg::*;

	// configuration
	coef_t             cos_q [NWHEEL];
	coef_t             sin_q [NWHEEL];
	logic [OFS_W-1:0]  offset_q;
	logic [LIM_W-1:0]  limit_q;

	// pipeline control
	logic                  en;
	logic [LAST_STAGE:1]   vld_q;
	logic [LAST_STAGE:6]   scl_q;
	logic                  skid_vld_q;

	// datapath
	rot_t   rot_s1;
	speed_t speed_s3 [NWHEEL];
	speed_t spd_s4   [NWHEEL];
	mag_t   mag_s4   [NWHEEL];
	speed_t spd_s5   [NWHEEL];
	mag_t   mag_s5   [NWHEEL];
	mag_t   largest_s5;
	mag_t   largest_d;
	speed_t spd_s6   [NWHEEL];
	num_t   num_s6   [NWHEEL];
	mag_t   den_s6;
	speed_t lane_out [NWHEEL];
	speed_t skid_spd_q [NWHEEL];
	logic   skid_scl_q;

	// ------------------------------------------------------------------
	// Configuration registers, unguarded by the block: to be written only while idle
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q[0] <= A_COS_RST;
			sin_q[0] <= A_SIN_RST;
			cos_q[1] <= B_COS_RST;
			sin_q[1] <= B_SIN_RST;
			cos_q[2] <= C_COS_RST;
			sin_q[2] <= C_SIN_RST;
			offset_q <= OFFSET_RST;
			limit_q  <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_wr_index))
				CFG_A_COS:  cos_q[0] <= cfg_wr_data[COEF_W-1:0];
				CFG_A_SIN:  sin_q[0] <= cfg_wr_data[COEF_W-1:0];
				CFG_B_COS:  cos_q[1] <= cfg_wr_data[COEF_W-1:0];
				CFG_B_SIN:  sin_q[1] <= cfg_wr_data[COEF_W-1:0];
				CFG_C_COS:  cos_q[2] <= cfg_wr_data[COEF_W-1:0];
				CFG_C_SIN:  sin_q[2] <= cfg_wr_data[COEF_W-1:0];
				CFG_OFFSET: offset_q <= cfg_wr_data[OFS_W-1:0];
				CFG_LIMIT:  limit_q  <= cfg_wr_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control: the whole pipeline advances while the skid is empty
	// ------------------------------------------------------------------
	assign en        = !skid_vld_q;
	assign cmd.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST_STAGE-1:1], cmd.valid};
		end
	end

	// ------------------------------------------------------------------
	// Stages 1..3: per-wheel projection; rotation term shared by all wheels
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= cmd.turn_rate * $signed({1'b0, offset_q});
		end
	end

	for (genvar w = 0; w < NWHEEL; w++) begin : g_front
		kdik_wheel_front u_front (
			.clk      (clk),
			.en       (en),
			.vel_x    (cmd.vel_x),
			.vel_y    (cmd.vel_y),
			.coef_cos (cos_q[w]),
			.coef_sin (sin_q[w]),
			.rot_s1   (rot_s1),
			.speed_s3 (speed_s3[w])
		);
	end

	// ------------------------------------------------------------------
	// Stages 4..6: magnitudes, largest, numerators and scale decision
	// ------------------------------------------------------------------
	always_comb begin
		largest_d = mag_s4[0];
		if (mag_s4[1] > largest_d) begin
			largest_d = mag_s4[1];
		end
		if (mag_s4[2] > largest_d) begin
			largest_d = mag_s4[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int w = 0; w < NWHEEL; w++) begin
				spd_s4[w] <= speed_s3[w];
				mag_s4[w] <= speed_s3[w][SPD_W-1] ? MAG_W'(-speed_s3[w])
				                                  : speed_s3[w][MAG_W-1:0];
				spd_s5[w] <= spd_s4[w];
				mag_s5[w] <= mag_s4[w];
				spd_s6[w] <= spd_s5[w];
				num_s6[w] <= mag_s5[w] * limit_q;
			end
			largest_s5 <= largest_d;
			den_s6     <= largest_s5;
		end
	end

	// scale flag: set when the largest magnitude is over the limit; carry it along
	always_ff @(posedge clk) begin
		if (en) begin
			scl_q <= {scl_q[LAST_STAGE-1:6], largest_s5 > limit_q};
		end
	end

	// ------------------------------------------------------------------
	// Stages 7..27: divide magnitude*limit by the largest; pass unscaled speed or restore sign
	// ------------------------------------------------------------------
	for (genvar w = 0; w < NWHEEL; w++) begin : g_lane
		kdik_div_lane u_lane (
			.clk       (clk),
			.en        (en),
			.num       (num_s6[w]),
			.den       (den_s6),
			.spd       (spd_s6[w]),
			.scaled    (scl_q[LAST_STAGE-1]),
			.speed_out (lane_out[w])
		);
	end

	// ------------------------------------------------------------------
	// Skid register: park the last-stage result when the sink stalls
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			skid_vld_q <= vld_q[LAST_STAGE] && !wheel.ready;
		end else if (wheel.ready) begin
			skid_vld_q <= 1'b0;
		end
	end

	// load while empty; hold while full
	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_spd_q <= lane_out;
			skid_scl_q <= scl_q[LAST_STAGE];
		end
	end

	assign wheel.valid         = skid_vld_q || vld_q[LAST_STAGE];
	assign wheel.wheel_a_speed = skid_vld_q ? skid_spd_q[0] : lane_out[0];
	assign wheel.wheel_b_speed = skid_vld_q ? skid_spd_q[1] : lane_out[1];
	assign wheel.wheel_c_speed = skid_vld_q ? skid_spd_q[2] : lane_out[2];
	assign wheel.was_scaled    = skid_vld_q ? skid_scl_q    : scl_q[LAST_STAGE];

endmodule

### sv/kdik_checker.sv
// ----------------------------------------------------------------------------
// kdik_checker
// Port-level checks of the kiwi drive unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "kiwi_drive_inverse_kinematics_unit_assert.svh"

module kdik_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_ready,
	input logic        wheel_valid,
	input logic        wheel_ready,
	input logic [20:0] wheel_a_speed,
	input logic [20:0] wheel_b_speed,
	input logic [20:0] wheel_c_speed,
	input logic        was_scaled
);

	`KDIK_ASSERT_NEXT(a_out_valid_hold, clk, arst_n, wheel_valid && !wheel_ready, wheel_valid, "result dropped while stalled")

	`KDIK_ASSERT_NEXT(a_out_data_hold, clk, arst_n, wheel_valid && !wheel_ready, $stable(wheel_a_speed) && $stable(wheel_b_speed) && $stable(wheel_c_speed) && $stable(was_scaled), "stalled result changed")

	// speeds are saturated symmetrically, so the most negative code never shows
	`KDIK_ASSERT_IMPLY(a_speed_range, clk, arst_n, wheel_valid, wheel_a_speed != 21'h100000 && wheel_b_speed != 21'h100000 && wheel_c_speed != 21'h100000, "wheel speed out of range")

	// input back-pressure only follows a stalled result
	`KDIK_ASSERT_IMPLY(a_ready_cause, clk, arst_n, !cmd_ready, $past(wheel_valid && !wheel_ready), "input stalled without output stall")

endmodule

bind kiwi_drive_inverse_kinematics_unit kdik_checker u_kdik_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_ready     (cmd.ready),
	.wheel_valid   (wheel.valid),
	.wheel_ready   (wheel.ready),
	.wheel_a_speed (wheel.wheel_a_speed),
	.wheel_b_speed (wheel.wheel_b_speed),
	.wheel_c_speed (wheel.wheel_c_speed),
	.was_scaled    (wheel.was_scaled)
);

### verif/kdik_checker.sv
// ----------------------------------------------------------------------------
// kdik_tb_checker
// Watches the command, wheel and register ports of the kiwi drive unit,
// predicts the wheel speeds of every accepted request and compares them.
// ----------------------------------------------------------------------------
module kdik_tb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	kdik_cmd_if                             cmd,
	kdik_wheel_if                           wheel,
	input  logic                            cfg_wr_en,
	input  logic [kdik_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
	input  logic [kdik_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	output int                              fail_count,
	output int                              results_seen,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import kdik_pkg::*;

	typedef struct packed {
		speed_t a;
		speed_t b;
		speed_t c;
		logic   scaled;
	} wheel_set_t;

	coef_t             cos_q [NWHEEL];
	coef_t             sin_q [NWHEEL];
	logic [OFS_W-1:0]  offset_q;
	logic [LIM_W-1:0]  limit_q;
	wheel_set_t        wheel_set_q [$];

	function automatic wheel_set_t solve_wheels(input vel_t vx, input vel_t vy, input vel_t tr);
		longint     spd [NWHEEL];
		longint     mag_v [NWHEEL];
		longint     sum;
		longint     big;
		longint     lim;
		wheel_set_t r;
		big = 0;
		lim = longint'(limit_q);
		for (int i = 0; i < NWHEEL; i++) begin
			// Q.14 sum; the rotation term is Q.8 and moves up by 6 bits
			sum = longint'(vx) * longint'(cos_q[i]) + longint'(vy) * longint'(sin_q[i])
				+ longint'(tr) * longint'(offset_q) * 64;
			spd[i] = sum / 16384;
			if (spd[i] > 1048575)
				spd[i] = 1048575;
			if (spd[i] < -1048575)
				spd[i] = -1048575;
			mag_v[i] = (spd[i] < 0) ? -spd[i] : spd[i];
			if (mag_v[i] > big)
				big = mag_v[i];
		end
		r.scaled = (big > lim);
		if (r.scaled) begin
			for (int i = 0; i < NWHEEL; i++) begin
				mag_v[i] = (mag_v[i] * lim) / big;
				spd[i] = (spd[i] < 0) ? -mag_v[i] : mag_v[i];
			end
		end
		r.a = speed_t'(spd[0]);
		r.b = speed_t'(spd[1]);
		r.c = speed_t'(spd[2]);
		return r;
	endfunction

	function automatic int field_mismatch(input string name, input speed_t want, input speed_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		wheel_set_t want;
		int         errs;
		if (!arst_n) begin
			cos_q[0]     <= A_COS_RST;
			sin_q[0]     <= A_SIN_RST;
			cos_q[1]     <= B_COS_RST;
			sin_q[1]     <= B_SIN_RST;
			cos_q[2]     <= C_COS_RST;
			sin_q[2]     <= C_SIN_RST;
			offset_q     <= OFFSET_RST;
			limit_q      <= LIMIT_RST;
			fail_count   <= 0;
			results_seen <= 0;
			pending      <= 0;
			wheel_set_q.delete();
		end else begin
			errs = 0;
			if (cmd.valid && cmd.ready)
				wheel_set_q.push_back(solve_wheels(cmd.vel_x, cmd.vel_y, cmd.turn_rate));
			if (wheel.valid && wheel.ready) begin
				if (wheel_set_q.size() == 0) begin
					$error("wheel result with no request outstanding");
					errs++;
				end else begin
					want = wheel_set_q.pop_front();
					errs += field_mismatch("wheel_a_speed", want.a, wheel.wheel_a_speed);
					errs += field_mismatch("wheel_b_speed", want.b, wheel.wheel_b_speed);
					errs += field_mismatch("wheel_c_speed", want.c, wheel.wheel_c_speed);
					errs += field_mismatch("was_scaled", speed_t'(want.scaled),
						speed_t'(wheel.was_scaled));
				end
				results_seen <= results_seen + 1;
			end
			if (cfg_wr_en) begin
				case (cfg_wr_index)
					CFG_A_COS:  cos_q[0] <= coef_t'(cfg_wr_data[COEF_W-1:0]);
					CFG_A_SIN:  sin_q[0] <= coef_t'(cfg_wr_data[COEF_W-1:0]);
					CFG_B_COS:  cos_q[1] <= coef_t'(cfg_wr_data[COEF_W-1:0]);
					CFG_B_SIN:  sin_q[1] <= coef_t'(cfg_wr_data[COEF_W-1:0]);
					CFG_C_COS:  cos_q[2] <= coef_t'(cfg_wr_data[COEF_W-1:0]);
					CFG_C_SIN:  sin_q[2] <= coef_t'(cfg_wr_data[COEF_W-1:0]);
					CFG_OFFSET: offset_q <= cfg_wr_data[OFS_W-1:0];
					CFG_LIMIT:  limit_q  <= cfg_wr_data[LIM_W-1:0];
					default: ;
				endcase
			end
			fail_count <= fail_count + errs;
			pending    <= wheel_set_q.size();
		end
	end

endmodule

### verif/tb_kiwi_drive_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// tb_kiwi_drive_inverse_kinematics_unit
// Drives velocity requests and register settings into the kiwi drive unit
// under several idling patterns; a checker beside the unit predicts every
// set of wheel speeds and counts mismatches.
// ----------------------------------------------------------------------------
module tb_kiwi_drive_inverse_kinematics_unit;
	import kdik_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// No handshake for this many cycles means the unit has hung. The slowest
	// legal gap is a drain through the whole pipeline under heavy stall plus
	// eight register writes, far below this.
	localparam int WATCHDOG_LIMIT = 3000;
	// Extra cycles to watch for stray results once everything has come back.
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 65;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_wr_index;
	logic [CFG_DATA_W-1:0] cfg_wr_data;

	int fail_count;
	int results_seen;
	int pending;
	int requests_sent;
	int quiet_cycles;
	int send_idle_pct;
	int recv_stall_pct;

	logic [CFG_DATA_W-1:0] cfg_vals [8];

	kdik_cmd_if   cmd_ch ();
	kdik_wheel_if wheel_ch ();

	kiwi_drive_inverse_kinematics_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.wheel        (wheel_ch),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_index (cfg_wr_index),
		.cfg_wr_data  (cfg_wr_data)
	);

	kdik_tb_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.wheel        (wheel_ch),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_index (cfg_wr_index),
		.cfg_wr_data  (cfg_wr_data),
		.fail_count   (fail_count),
		.results_seen (results_seen),
		.pending      (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Hold ready low through reset, then stall at the rate of the current phase.
	initial begin
		wheel_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			wheel_ch.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
		end
	end

	// Count cycles with no handshake on either channel; give up at the limit.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (wheel_ch.valid && wheel_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct  = 75;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = 75;
			end
			default: begin
				send_idle_pct  = 15;
				recv_stall_pct = 15;
			end
		endcase
	endtask

	// Offer one request, idling first at the phase rate; return once accepted.
	// Leave valid high so back-to-back requests need no extra assignment.
	task automatic push_cmd(input vel_t vx, input vel_t vy, input vel_t tr);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.vel_x     <= vx;
		cmd_ch.vel_y     <= vy;
		cmd_ch.turn_rate <= tr;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	// Drop valid and wait until every outstanding request has its result.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_seen != requests_sent)
			@(posedge clk);
	endtask

	// Write all eight registers from cfg_vals while the unit is empty.
	task automatic commit_config();
		drain();
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en    <= 1'b1;
			cfg_wr_index <= cfg_idx_t'(i);
			cfg_wr_data  <= cfg_vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Angle coefficient word; the top four bits are junk the unit must ignore.
	function automatic logic [CFG_DATA_W-1:0] rand_coef_word();
		logic [3:0]        junk;
		logic [COEF_W-1:0] c;
		junk = 4'($urandom);
		case ($urandom_range(9))
			0: c = 16'h4000;
			1: c = 16'hC000;
			2: c = 16'hE000;
			3: c = 16'd14189;
			4: c = 16'(-14189);
			5: c = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
			6: c = 16'h0000;
			default: c = 16'($urandom);
		endcase
		return {junk, c};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_limit_word();
		case ($urandom_range(9))
			0: return 20'h00000;
			1: return 20'hFFFFF;
			2: return 20'($urandom);
			3: return 20'($urandom_range(1, 20));
			default: return 20'($urandom_range(1, 40000));
		endcase
	endfunction

	function automatic vel_t rand_vel(input int kind);
		case (kind)
			0: return vel_t'($urandom);
			1: return vel_t'(int'($urandom_range(8000)) - 4000);
			2: return vel_t'(int'($urandom_range(512)) - 256);
			default: begin
				case ($urandom_range(4))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0001;
					3: return 16'shFFFF;
					default: return 16'sh0000;
				endcase
			end
		endcase
	endfunction

	// Half full-range commands, the rest small ones, single-axis moves and corner
	// values; pause once midway for a full drain.
	task automatic run_random(input int count);
		int   kind;
		vel_t vx;
		vel_t vy;
		vel_t tr;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				drain();
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: kind = 0;
				10, 11, 12, 13, 14:           kind = 1;
				15, 16:                       kind = 2;
				default:                      kind = 3;
			endcase
			vx = rand_vel(kind);
			vy = rand_vel(kind);
			tr = rand_vel((kind == 1) ? 2 : kind);
			if (kind == 2) begin
				// one axis only
				case ($urandom_range(2))
					0: begin
						vy = '0;
						tr = '0;
					end
					1: begin
						vx = '0;
						tr = '0;
					end
					default: begin
						vx = '0;
						vy = '0;
					end
				endcase
			end
			push_cmd(vx, vy, tr);
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.vel_x     = '0;
		cmd_ch.vel_y     = '0;
		cmd_ch.turn_rate = '0;
		cfg_wr_en        = 1'b0;
		cfg_wr_index     = '0;
		cfg_wr_data      = '0;
		requests_sent    = 0;
		set_idle(IDLE_NONE);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry, limit 4000: zero command, limit met exactly and just
		// exceeded, every field at both extremes, a small spin.
		push_cmd(16'sd0, 16'sd0, 16'sd0);
		push_cmd(16'sd4000, 16'sd0, 16'sd0);
		push_cmd(16'sd4001, 16'sd0, 16'sd0);
		push_cmd(16'sh7FFF, 16'sd0, 16'sd0);
		push_cmd(16'sh8000, 16'sd0, 16'sd0);
		push_cmd(16'sd0, 16'sh7FFF, 16'sd0);
		push_cmd(16'sd0, 16'sh8000, 16'sd0);
		push_cmd(16'sd0, 16'sd0, 16'sh7FFF);
		push_cmd(16'sd0, 16'sd0, 16'sh8000);
		push_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		push_cmd(16'sh8000, 16'sh8000, 16'sh8000);
		push_cmd(16'sd0, 16'sd0, 16'sd256);
		push_cmd(-16'sd1, -16'sd1, -16'sd1);
		push_cmd(16'sd1, 16'sd1, 16'sd1);

		// Coefficients up to the ends of the Q1.14 range, widest offset, top limit.
		cfg_vals[CFG_A_COS]  = 20'hA8000;
		cfg_vals[CFG_A_SIN]  = 20'h07FFF;
		cfg_vals[CFG_B_COS]  = 20'hF4000;
		cfg_vals[CFG_B_SIN]  = 20'h0C000;
		cfg_vals[CFG_C_COS]  = 20'h57FFF;
		cfg_vals[CFG_C_SIN]  = 20'h08000;
		cfg_vals[CFG_OFFSET] = 20'hFFFFF;
		cfg_vals[CFG_LIMIT]  = 20'hFFFFF;
		commit_config();
		set_idle(IDLE_BOTH);
		push_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		push_cmd(16'sh8000, 16'sh8000, 16'sh8000);
		push_cmd(16'sh7FFF, 16'sh8000, 16'sh7FFF);
		push_cmd(16'sh8000, 16'sh7FFF, 16'sh8000);
		run_random(30);

		// Zero limit: any nonzero speed collapses to zero with the flag set,
		// while an all-zero result passes unflagged.
		cfg_vals[CFG_A_COS]  = 20'h04000;
		cfg_vals[CFG_A_SIN]  = 20'h00000;
		cfg_vals[CFG_B_COS]  = 20'(16'(-8192));
		cfg_vals[CFG_B_SIN]  = 20'd14189;
		cfg_vals[CFG_C_COS]  = 20'(16'(-8192));
		cfg_vals[CFG_C_SIN]  = 20'(16'(-14189));
		cfg_vals[CFG_OFFSET] = 20'd200;
		cfg_vals[CFG_LIMIT]  = 20'd0;
		commit_config();
		set_idle(IDLE_SEND);
		push_cmd(16'sd0, 16'sd0, 16'sd0);
		push_cmd(16'sd1, 16'sd0, 16'sd0);
		push_cmd(16'sd0, 16'sd0, 16'sd1);
		run_random(30);

		// Limit of one, no wheel offset so rotation drops out.
		cfg_vals[CFG_OFFSET] = 20'd0;
		cfg_vals[CFG_LIMIT]  = 20'd1;
		commit_config();
		set_idle(IDLE_RECV);
		push_cmd(16'sd0, 16'sd0, 16'sh7FFF);
		push_cmd(16'sd2, 16'sd0, 16'sd0);
		run_random(30);

		// Random geometries, cycling through the idling patterns.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int r = CFG_A_COS; r <= CFG_C_SIN; r++)
				cfg_vals[r] = rand_coef_word();
			cfg_vals[CFG_OFFSET] = ($urandom_range(3) == 0) ? 20'($urandom_range(50, 400))
				: 20'($urandom);
			cfg_vals[CFG_LIMIT] = rand_limit_word();
			commit_config();
			set_idle(idle_mode_t'(ph % 4));
			run_random(ITEMS_PER_PHASE);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending != 0)
			$error("%0d wheel results never arrived", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
